// File: rtl/core/svrm_pkg.sv
package svrm_pkg;

   // size of the supported value range and the widths that follow from it
   localparam int RANGE_SIZE = 65536;
   localparam int IDX_W      = $clog2(RANGE_SIZE);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CALC_W     = (CNT_W + 3 > 20) ? CNT_W + 3 : 20;

   // field widths
   localparam int MODE_W    = 3;
   localparam int OPERAND_W = 18;
   localparam int PRED_W    = 17;
   localparam int RESULT_W  = 18;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 1;

   // command codes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MARK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BUILD = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MAP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNMAP = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VALUE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALUE = 1'd1;

   // sequencer states
   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_CLEAR    = 11'b000_0000_0010,
      ST_BUILD    = 11'b000_0000_0100,
      ST_RD_CI    = 11'b000_0000_1000,
      ST_RD_FI    = 11'b000_0001_0000,
      ST_RD_T     = 11'b000_0010_0000,
      ST_RK_CEIL  = 11'b000_0100_0000,
      ST_RK_FLOOR = 11'b000_1000_0000,
      ST_DECIDE   = 11'b001_0000_0000,
      ST_RD_R     = 11'b010_0000_0000,
      ST_UNMAP    = 11'b100_0000_0000
   } state_type;

endpackage

// File: rtl/core/sparse_value_rank_mapper_core.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------------------------
// request   | in        | start high while busy low  | req_mode, req_operand_value,
//           |           |                            | req_prediction
// response  | out       | rsp_valid one-cycle strobe | rsp_result_value, rsp_error,
//           |           |                            | rsp_used_count
// csr       | in        | csr_valid and csr_ready    | csr_index, csr_data
//
// mark and unused codes answer in the cycle after the accept, and a new beat can follow at once.
// map and unmap run a chain of dependent registered reads from the bitmap, prefix and rank
// memories (RD_CI, RD_FI, RD_T, RK_CEIL, RK_FLOOR, DECIDE, RD_R, plus UNMAP for unmap).
// build walks one bitmap entry per cycle over the range size; clear sweeps the whole bitmap,
// one entry per cycle, and reset starts the same clearing pass (no response) with busy high
// until it ends. the response cannot be held off; csr writes are taken in every cycle.
module sparse_value_rank_mapper_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [svrm_pkg::MODE_W-1:0]                req_mode,
   input  logic signed [svrm_pkg::OPERAND_W-1:0]      req_operand_value,
   input  logic signed [svrm_pkg::PRED_W-1:0]         req_prediction,
   output logic                                       rsp_valid,
   output logic signed [svrm_pkg::RESULT_W-1:0]       rsp_result_value,
   output logic                                       rsp_error,
   output logic [svrm_pkg::CNT_W-1:0]                 rsp_used_count,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [svrm_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic signed [svrm_pkg::CFG_W-1:0]          csr_data
);

   // memories
   logic                          used_map_ff [svrm_pkg::RANGE_SIZE];
   logic [svrm_pkg::CNT_W-1:0]    prefix_ff   [svrm_pkg::RANGE_SIZE];
   logic [svrm_pkg::IDX_W-1:0]    rank_ff     [svrm_pkg::RANGE_SIZE];

   logic                          um_we, um_wdata, um_rd_ff;
   logic [svrm_pkg::IDX_W-1:0]    um_waddr, um_raddr;
   logic                          pc_we;
   logic [svrm_pkg::IDX_W-1:0]    pc_waddr, pc_raddr;
   logic [svrm_pkg::CNT_W-1:0]    pc_wdata, pc_rd_ff;
   logic                          rk_we;
   logic [svrm_pkg::IDX_W-1:0]    rk_waddr, rk_raddr, rk_wdata, rk_rd_ff;

   // control state
   svrm_pkg::state_type           state_ff, state_in;
   logic                          clr_cmd_ff, clr_cmd_in;
   logic [svrm_pkg::CNT_W-1:0]    walk_ff, walk_in;
   logic                          pend_ff, pend_in;
   logic [svrm_pkg::CNT_W-1:0]    total_used_ff, total_used_in;
   logic signed [svrm_pkg::CFG_W-1:0] min_ff, min_in, max_ff, max_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [svrm_pkg::IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [svrm_pkg::CNT_W-1:0]    run_ff, run_in;
   logic                          is_unmap_ff, is_unmap_in;
   logic signed [svrm_pkg::CALC_W-1:0] v_ff, v_in, p_ff, p_in;
   logic [svrm_pkg::IDX_W-1:0]    ci_ff, ci_in, fi_ff, fi_in, t_ff, t_in;
   logic                          ci_end_ff, ci_end_in, fi_end_ff, fi_end_in;
   logic                          t_bad_ff, t_bad_in, t_used_ff, t_used_in;
   logic [svrm_pkg::CNT_W-1:0]    ceil_rank_ff, ceil_rank_in, pt_rank_ff, pt_rank_in;
   logic signed [svrm_pkg::CALC_W-1:0] floor_rank_ff, floor_rank_in, base_ff, base_in;
   logic [svrm_pkg::IDX_W-1:0]    ceil_idx_ff, ceil_idx_in;
   logic                          r_bad_ff, r_bad_in;
   logic signed [svrm_pkg::RESULT_W-1:0] rsp_value_ff, rsp_value_in;
   logic                          rsp_error_ff, rsp_error_in;

   // arithmetic helpers
   logic signed [svrm_pkg::CALC_W-1:0] min_s, max_s, span_s, n_s, total_s;
   logic signed [svrm_pkg::CALC_W-1:0] v_req_s, p_req_s, pidx_s, fidx_s, ci_s, fi_s, t_s;
   logic signed [svrm_pkg::CALC_W-1:0] mark_idx_s, ceil_s, ceil_dist_s, floor_dist_s;
   logic signed [svrm_pkg::CALC_W-1:0] map_res_s, rank_r_s, unmap_res_s;
   logic [svrm_pkg::CNT_W-1:0]    range_n;
   logic                          accept, mark_bad, build_issue;

   assign accept         = start && !busy;
   assign busy           = (state_ff != svrm_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_error      = rsp_error_ff;
   assign rsp_used_count = total_used_ff;

   // range size from the current registers, limited to the memory depth
   always_comb begin
      min_s  = svrm_pkg::CALC_W'(min_ff);
      max_s  = svrm_pkg::CALC_W'(max_ff);
      span_s = max_s - min_s + svrm_pkg::CALC_W'(1);
      if (span_s < 0) begin
         range_n = '0;
      end else if (span_s > svrm_pkg::CALC_W'(svrm_pkg::RANGE_SIZE)) begin
         range_n = svrm_pkg::CNT_W'(svrm_pkg::RANGE_SIZE);
      end else begin
         range_n = span_s[svrm_pkg::CNT_W-1:0];
      end
      n_s     = signed'(svrm_pkg::CALC_W'(range_n));
      total_s = signed'(svrm_pkg::CALC_W'(total_used_ff));
   end

   // pivot, target and mark indexes of the incoming beat
   always_comb begin
      v_req_s    = svrm_pkg::CALC_W'(req_operand_value);
      p_req_s    = svrm_pkg::CALC_W'(req_prediction);
      pidx_s     = p_req_s - min_s;
      fidx_s     = pidx_s + svrm_pkg::CALC_W'(1);
      t_s        = v_req_s + pidx_s;
      mark_idx_s = v_req_s - min_s;
      mark_bad   = (mark_idx_s < 0) || (mark_idx_s >= n_s);
      if (pidx_s < 0) begin
         ci_s = '0;
      end else if (pidx_s > n_s) begin
         ci_s = n_s;
      end else begin
         ci_s = pidx_s;
      end
      if (fidx_s < 0) begin
         fi_s = '0;
      end else if (fidx_s > n_s) begin
         fi_s = n_s;
      end else begin
         fi_s = fidx_s;
      end
   end

   // base rank choice and final arithmetic
   always_comb begin
      ceil_s       = signed'(svrm_pkg::CALC_W'(ceil_rank_ff));
      ceil_dist_s  = min_s + signed'(svrm_pkg::CALC_W'(ceil_idx_ff)) - p_ff;
      floor_dist_s = p_ff - (min_s + signed'(svrm_pkg::CALC_W'(rk_rd_ff)));
      map_res_s    = signed'(svrm_pkg::CALC_W'(pt_rank_ff)) - base_ff;
      rank_r_s     = base_ff + v_ff;
      unmap_res_s  = signed'(svrm_pkg::CALC_W'(rk_rd_ff)) + min_s - p_ff;
      build_issue  = (walk_ff < range_n);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cmd_in    = clr_cmd_ff;
      walk_in       = walk_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      run_in        = run_ff;
      total_used_in = total_used_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_error_in  = rsp_error_ff;
      is_unmap_in   = is_unmap_ff;
      v_in          = v_ff;
      p_in          = p_ff;
      ci_in         = ci_ff;
      fi_in         = fi_ff;
      t_in          = t_ff;
      ci_end_in     = ci_end_ff;
      fi_end_in     = fi_end_ff;
      t_bad_in      = t_bad_ff;
      t_used_in     = t_used_ff;
      ceil_rank_in  = ceil_rank_ff;
      floor_rank_in = floor_rank_ff;
      pt_rank_in    = pt_rank_ff;
      ceil_idx_in   = ceil_idx_ff;
      base_in       = base_ff;
      r_bad_in      = r_bad_ff;

      um_we    = 1'b0;
      um_waddr = mark_idx_s[svrm_pkg::IDX_W-1:0];
      um_wdata = 1'b1;
      um_raddr = t_ff;
      pc_we    = 1'b0;
      pc_waddr = pend_idx_ff;
      pc_wdata = run_ff;
      pc_raddr = ci_ff;
      rk_we    = 1'b0;
      rk_waddr = run_ff[svrm_pkg::IDX_W-1:0];
      rk_wdata = pend_idx_ff;
      rk_raddr = ceil_rank_ff[svrm_pkg::IDX_W-1:0];

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            svrm_pkg::REG_MIN_VALUE: min_in = csr_data;
            svrm_pkg::REG_MAX_VALUE: max_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         svrm_pkg::ST_IDLE: begin
            // capture operands for a lookup
            is_unmap_in = (req_mode == svrm_pkg::MODE_UNMAP);
            v_in        = v_req_s;
            p_in        = p_req_s;
            ci_in       = ci_s[svrm_pkg::IDX_W-1:0];
            fi_in       = fi_s[svrm_pkg::IDX_W-1:0];
            ci_end_in   = (ci_s == n_s);
            fi_end_in   = (fi_s == n_s);
            t_in        = t_s[svrm_pkg::IDX_W-1:0];
            t_bad_in    = (t_s < 0) || (t_s >= n_s);
            if (accept) begin
               case (req_mode)
                  svrm_pkg::MODE_CLEAR: begin
                     state_in   = svrm_pkg::ST_CLEAR;
                     walk_in    = '0;
                     clr_cmd_in = 1'b1;
                  end
                  svrm_pkg::MODE_MARK: begin
                     um_we        = !mark_bad;
                     rsp_valid_in = 1'b1;
                     rsp_error_in = mark_bad;
                     rsp_value_in = '0;
                  end
                  svrm_pkg::MODE_BUILD: begin
                     state_in = svrm_pkg::ST_BUILD;
                     walk_in  = '0;
                     run_in   = '0;
                     pend_in  = 1'b0;
                  end
                  svrm_pkg::MODE_MAP, svrm_pkg::MODE_UNMAP: begin
                     state_in = svrm_pkg::ST_RD_CI;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_error_in = 1'b0;
                     rsp_value_in = '0;
                  end
               endcase
            end
         end
         svrm_pkg::ST_CLEAR: begin
            // sweep the whole bitmap
            um_we    = 1'b1;
            um_waddr = walk_ff[svrm_pkg::IDX_W-1:0];
            um_wdata = 1'b0;
            walk_in  = walk_ff + svrm_pkg::CNT_W'(1);
            if (walk_ff == svrm_pkg::CNT_W'(svrm_pkg::RANGE_SIZE - 1)) begin
               state_in     = svrm_pkg::ST_IDLE;
               clr_cmd_in   = 1'b0;
               rsp_valid_in = clr_cmd_ff;
               rsp_error_in = 1'b0;
               rsp_value_in = '0;
            end
         end
         svrm_pkg::ST_BUILD: begin
            // issue bitmap reads, one entry behind write the tables
            um_raddr    = walk_ff[svrm_pkg::IDX_W-1:0];
            pend_in     = build_issue;
            pend_idx_in = walk_ff[svrm_pkg::IDX_W-1:0];
            if (build_issue) begin
               walk_in = walk_ff + svrm_pkg::CNT_W'(1);
            end
            if (pend_ff) begin
               pc_we = 1'b1;
               if (um_rd_ff) begin
                  rk_we  = 1'b1;
                  run_in = run_ff + svrm_pkg::CNT_W'(1);
               end
            end
            if (!build_issue && !pend_ff) begin
               state_in      = svrm_pkg::ST_IDLE;
               total_used_in = run_ff;
               rsp_valid_in  = 1'b1;
               rsp_error_in  = 1'b0;
               rsp_value_in  = '0;
            end
         end
         svrm_pkg::ST_RD_CI: begin
            pc_raddr = ci_ff;
            um_raddr = t_ff;
            state_in = svrm_pkg::ST_RD_FI;
         end
         svrm_pkg::ST_RD_FI: begin
            ceil_rank_in = ci_end_ff ? total_used_ff : pc_rd_ff;
            t_used_in    = um_rd_ff;
            pc_raddr     = fi_ff;
            state_in     = svrm_pkg::ST_RD_T;
         end
         svrm_pkg::ST_RD_T: begin
            floor_rank_in = signed'(svrm_pkg::CALC_W'(fi_end_ff ? total_used_ff : pc_rd_ff))
                            - svrm_pkg::CALC_W'(1);
            pc_raddr      = t_ff;
            state_in      = svrm_pkg::ST_RK_CEIL;
         end
         svrm_pkg::ST_RK_CEIL: begin
            pt_rank_in = pc_rd_ff;
            rk_raddr   = ceil_rank_ff[svrm_pkg::IDX_W-1:0];
            state_in   = svrm_pkg::ST_RK_FLOOR;
         end
         svrm_pkg::ST_RK_FLOOR: begin
            ceil_idx_in = rk_rd_ff;
            rk_raddr    = floor_rank_ff[svrm_pkg::IDX_W-1:0];
            state_in    = svrm_pkg::ST_DECIDE;
         end
         svrm_pkg::ST_DECIDE: begin
            // nearest used value to the prediction, ties to the lower one
            if (floor_rank_ff < 0) begin
               base_in = ceil_s;
            end else if (ceil_s >= total_s) begin
               base_in = floor_rank_ff;
            end else if (floor_rank_ff == ceil_s) begin
               base_in = ceil_s;
            end else if (floor_dist_s <= ceil_dist_s) begin
               base_in = floor_rank_ff;
            end else begin
               base_in = ceil_s;
            end
            state_in = svrm_pkg::ST_RD_R;
         end
         svrm_pkg::ST_RD_R: begin
            if (is_unmap_ff) begin
               r_bad_in = (rank_r_s < 0) || (rank_r_s >= total_s);
               rk_raddr = rank_r_s[svrm_pkg::IDX_W-1:0];
               state_in = svrm_pkg::ST_UNMAP;
            end else begin
               state_in     = svrm_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_error_in = t_bad_ff || !t_used_ff;
               rsp_value_in = (t_bad_ff || !t_used_ff) ? '0
                              : map_res_s[svrm_pkg::RESULT_W-1:0];
            end
         end
         svrm_pkg::ST_UNMAP: begin
            state_in     = svrm_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_error_in = r_bad_ff;
            rsp_value_in = r_bad_ff ? '0 : unmap_res_s[svrm_pkg::RESULT_W-1:0];
         end
         default: begin
            state_in = svrm_pkg::ST_IDLE;
         end
      endcase
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (um_we) begin
         used_map_ff[um_waddr] <= um_wdata;
      end
      um_rd_ff <= used_map_ff[um_raddr];
   end

   // prefix count memory
   always_ff @(posedge clock) begin
      if (pc_we) begin
         prefix_ff[pc_waddr] <= pc_wdata;
      end
      pc_rd_ff <= prefix_ff[pc_raddr];
   end

   // rank to index memory
   always_ff @(posedge clock) begin
      if (rk_we) begin
         rank_ff[rk_waddr] <= rk_wdata;
      end
      rk_rd_ff <= rank_ff[rk_raddr];
   end

   // control registers, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= svrm_pkg::ST_CLEAR;
         clr_cmd_ff    <= 1'b0;
         walk_ff       <= '0;
         pend_ff       <= 1'b0;
         total_used_ff <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cmd_ff    <= clr_cmd_in;
         walk_ff       <= walk_in;
         pend_ff       <= pend_in;
         total_used_ff <= total_used_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      run_ff        <= run_in;
      is_unmap_ff   <= is_unmap_in;
      v_ff          <= v_in;
      p_ff          <= p_in;
      ci_ff         <= ci_in;
      fi_ff         <= fi_in;
      t_ff          <= t_in;
      ci_end_ff     <= ci_end_in;
      fi_end_ff     <= fi_end_in;
      t_bad_ff      <= t_bad_in;
      t_used_ff     <= t_used_in;
      ceil_rank_ff  <= ceil_rank_in;
      floor_rank_ff <= floor_rank_in;
      pt_rank_ff    <= pt_rank_in;
      ceil_idx_ff   <= ceil_idx_in;
      base_ff       <= base_in;
      r_bad_ff      <= r_bad_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_error_ff  <= rsp_error_in;
   end

   // checks
   a_mark_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == svrm_pkg::MODE_MARK) |=> rsp_valid)
      else $error("mark beat got no response in the next cycle");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == svrm_pkg::ST_BUILD) |-> (run_ff <= walk_ff))
      else $error("build rank counter ran ahead of the bitmap walk");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_result_value == '0))
      else $error("error response carries a nonzero value");

   a_lookup_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == svrm_pkg::ST_RD_CI) |-> ($past(state_ff) == svrm_pkg::ST_IDLE))
      else $error("lookup started without an accepted beat");

endmodule

// File: test/sparse_value_rank_mapper_core_test.sv
module sparse_value_rank_mapper_core_test;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RANDOM_BEATS = 1850;
   localparam int SMALL_SPAN   = 2048;

   // codes the block ignores
   localparam logic [svrm_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [svrm_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [svrm_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

   typedef struct packed {
      logic signed [svrm_pkg::RESULT_W-1:0] value;
      logic                                 err;
      logic [svrm_pkg::CNT_W-1:0]           count;
   } rank_answer_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [svrm_pkg::MODE_W-1:0]           req_mode;
   logic signed [svrm_pkg::OPERAND_W-1:0] req_operand_value;
   logic signed [svrm_pkg::PRED_W-1:0]    req_prediction;
   logic                                  rsp_valid;
   logic signed [svrm_pkg::RESULT_W-1:0]  rsp_result_value;
   logic                                  rsp_error;
   logic [svrm_pkg::CNT_W-1:0]            rsp_used_count;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [svrm_pkg::CSR_IDX_W-1:0]        csr_index;
   logic signed [svrm_pkg::CFG_W-1:0]     csr_data;

   sparse_value_rank_mapper_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_operand_value (req_operand_value),
      .req_prediction    (req_prediction),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_error         (rsp_error),
      .rsp_used_count    (rsp_used_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // shadow of the block: bitmap, prefix counts, rank table and bounds
   bit                       value_seen     [svrm_pkg::RANGE_SIZE];
   bit [svrm_pkg::CNT_W-1:0] below_count    [svrm_pkg::RANGE_SIZE];
   bit [svrm_pkg::IDX_W-1:0] rank_value_idx [svrm_pkg::RANGE_SIZE];
   longint         seen_total = 0;
   longint         lo_bound   = 0;
   longint         hi_bound   = 0;

   rank_answer_type rank_answers_due [$];
   int              mismatches  = 0;
   int              cycle_count = 0;
   int              sent_beats  = 0;
   bit              idle_on     = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow model
   function automatic longint span_size();
      longint n;
      n = hi_bound - lo_bound + 1;
      if (n < 0) n = 0;
      if (n > svrm_pkg::RANGE_SIZE) n = svrm_pkg::RANGE_SIZE;
      return n;
   endfunction

   function automatic longint below_at(input longint i, input longint n);
      if (i >= n || i < 0 || i >= svrm_pkg::RANGE_SIZE) return seen_total;
      return longint'(below_count[i]);
   endfunction

   function automatic longint value_idx_at(input longint r);
      if (r < 0 || r >= svrm_pkg::RANGE_SIZE) return 0;
      return longint'(rank_value_idx[r]);
   endfunction

   // rank of the used value nearest the pivot, ties to the lower value
   function automatic longint nearest_rank(input longint p, input longint n);
      longint pidx, ci, fi, ceil_r, floor_r, ceil_d, floor_d;
      pidx = p - lo_bound;
      ci = (pidx < 0) ? 0 : ((pidx > n) ? n : pidx);
      fi = pidx + 1;
      if (fi < 0) fi = 0;
      if (fi > n) fi = n;
      ceil_r  = below_at(ci, n);
      floor_r = below_at(fi, n) - 1;
      if (floor_r < 0) return ceil_r;
      if (ceil_r >= seen_total) return floor_r;
      if (floor_r == ceil_r) return ceil_r;
      ceil_d  = lo_bound + value_idx_at(ceil_r) - p;
      floor_d = p - (lo_bound + value_idx_at(floor_r));
      return (floor_d <= ceil_d) ? floor_r : ceil_r;
   endfunction

   function automatic rank_answer_type rank_response(
         input logic [svrm_pkg::MODE_W-1:0] mode,
         input logic signed [svrm_pkg::OPERAND_W-1:0] opv,
         input logic signed [svrm_pkg::PRED_W-1:0] pred);
      rank_answer_type ans;
      longint v, p, n, res, t, r, run, i;
      bit err;
      v = opv;
      p = pred;
      n = span_size();
      res = 0;
      err = 1'b0;
      case (mode)
         svrm_pkg::MODE_CLEAR: begin
            foreach (value_seen[k]) value_seen[k] = 1'b0;
         end
         svrm_pkg::MODE_MARK: begin
            t = v - lo_bound;
            if (t < 0 || t >= n) err = 1'b1;
            else value_seen[t] = 1'b1;
         end
         svrm_pkg::MODE_BUILD: begin
            run = 0;
            for (i = 0; i < n; i++) begin
               below_count[i] = run[svrm_pkg::CNT_W-1:0];
               if (value_seen[i]) begin
                  rank_value_idx[run] = i[svrm_pkg::IDX_W-1:0];
                  run++;
               end
            end
            seen_total = run;
         end
         svrm_pkg::MODE_MAP: begin
            t = v + p - lo_bound;
            if (t < 0 || t >= n || !value_seen[t]) err = 1'b1;
            else res = below_at(t, n) - nearest_rank(p, n);
         end
         svrm_pkg::MODE_UNMAP: begin
            r = nearest_rank(p, n) + v;
            if (r < 0 || r >= seen_total) err = 1'b1;
            else res = value_idx_at(r) + lo_bound - p;
         end
         default: ;
      endcase
      ans.value = res[svrm_pkg::RESULT_W-1:0];
      ans.err   = err;
      ans.count = seen_total[svrm_pkg::CNT_W-1:0];
      return ans;
   endfunction

   // random helpers
   function automatic longint pick_in(input longint a, input longint b);
      return a + longint'($urandom_range(0, b - a));
   endfunction

   function automatic longint pick_pivot(input longint centre, input longint lo, input longint hi);
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return centre + pick_in(-8, 8);
      if (k < 80 && hi >= lo) return pick_in(lo - 4, hi + 4);
      return pick_in(-65536, 65535);
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endfunction

   // response checking
   always @(posedge clock) begin : check_answers
      rank_answer_type due;
      if (!reset && rsp_valid) begin
         if (rank_answers_due.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: value %0d error %0b count %0d",
                                    rsp_result_value, rsp_error, rsp_used_count));
         end else begin
            due = rank_answers_due.pop_front();
            if (rsp_result_value !== due.value)
               note_mismatch($sformatf("result_value expected %0d got %0d",
                                       due.value, rsp_result_value));
            if (rsp_error !== due.err)
               note_mismatch($sformatf("error expected %0b got %0b", due.err, rsp_error));
            if (rsp_used_count !== due.count)
               note_mismatch($sformatf("used_count expected %0d got %0d",
                                       due.count, rsp_used_count));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // random hold-off before a beat, idle cycles added one by one at random
   task automatic idle_gap();
      while (idle_on && $urandom_range(0, 99) < 23)
         @(negedge clock);
   endtask

   // one command beat, expectation recorded at the accepting edge
   task automatic issue_command(input logic [svrm_pkg::MODE_W-1:0] mode, input longint opv,
                                input longint pred);
      idle_gap();
      start             = 1'b1;
      req_mode          = mode;
      req_operand_value = opv[svrm_pkg::OPERAND_W-1:0];
      req_prediction    = pred[svrm_pkg::PRED_W-1:0];
      do @(posedge clock); while (busy);
      rank_answers_due.push_back(rank_response(req_mode, req_operand_value, req_prediction));
      sent_beats++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // one csr write beat
   task automatic set_bound(input logic [svrm_pkg::CSR_IDX_W-1:0] idx, input longint value);
      logic signed [svrm_pkg::CFG_W-1:0] d;
      d = value[svrm_pkg::CFG_W-1:0];
      idle_gap();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      if (idx == svrm_pkg::REG_MIN_VALUE) lo_bound = d;
      else if (idx == svrm_pkg::REG_MAX_VALUE) hi_bound = d;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait until every answer is back and the block is idle
   task automatic settle();
      do @(posedge clock); while (rank_answers_due.size() != 0 || busy);
      @(negedge clock);
   endtask

   // marks under the reset range of one value
   task automatic test_reset_range();
      issue_command(svrm_pkg::MODE_MARK, 0, 0);
      issue_command(svrm_pkg::MODE_MARK, 1, 0);
   endtask

   // widest range: extremes, ignored codes, full build, ties and out-of-support
   task automatic test_full_range();
      settle();
      set_bound(svrm_pkg::REG_MIN_VALUE, -32768);
      set_bound(svrm_pkg::REG_MAX_VALUE, 32767);
      issue_command(svrm_pkg::MODE_MARK, -32768, 0);
      issue_command(svrm_pkg::MODE_MARK, 32767, 0);
      issue_command(svrm_pkg::MODE_MARK, 0, 0);
      issue_command(svrm_pkg::MODE_MARK, 32768, 0);
      issue_command(svrm_pkg::MODE_MARK, -131072, 0);
      issue_command(MODE_SPARE_A, 131071, -65536);
      issue_command(MODE_SPARE_B, -1, 65535);
      issue_command(MODE_SPARE_C, 0, 0);
      issue_command(svrm_pkg::MODE_BUILD, 0, 0);
      issue_command(svrm_pkg::MODE_MAP, 0, 0);
      // pivots clamped below and above the range
      issue_command(svrm_pkg::MODE_MAP, 32768, -65536);
      issue_command(svrm_pkg::MODE_MAP, -32768, 65535);
      issue_command(svrm_pkg::MODE_MAP, 5, 0);
      // pivot halfway between two used values
      issue_command(svrm_pkg::MODE_MAP, 16384, -16384);
      issue_command(svrm_pkg::MODE_UNMAP, 0, -16384);
      issue_command(svrm_pkg::MODE_UNMAP, 2, -32768);
      issue_command(svrm_pkg::MODE_UNMAP, 131071, 0);
      issue_command(svrm_pkg::MODE_UNMAP, -131072, 0);
   endtask

   // max below min gives no range at all
   task automatic test_empty_range();
      settle();
      set_bound(svrm_pkg::REG_MIN_VALUE, 5);
      set_bound(svrm_pkg::REG_MAX_VALUE, 4);
      issue_command(svrm_pkg::MODE_MARK, 5, 0);
      issue_command(svrm_pkg::MODE_MAP, 0, 5);
      issue_command(svrm_pkg::MODE_BUILD, 0, 0);
      issue_command(svrm_pkg::MODE_UNMAP, 0, 5);
   endtask

   task automatic test_clear_bitmap();
      issue_command(svrm_pkg::MODE_CLEAR, 0, 0);
   endtask

   // phases of new bounds, marks, a build and map/unmap traffic
   task automatic test_random_phases();
      logic [svrm_pkg::MODE_W-1:0] noise_modes [6];
      longint target_q [$];
      longint lo, hi, span, target, p, k, stop_at;
      int kind, clears_left;
      noise_modes = '{svrm_pkg::MODE_MARK, svrm_pkg::MODE_MAP, svrm_pkg::MODE_UNMAP,
                      MODE_SPARE_A, MODE_SPARE_B, MODE_SPARE_C};
      clears_left = 2;
      stop_at = sent_beats + RANDOM_BEATS;
      while (sent_beats < stop_at) begin
         // one long stretch without idling
         idle_on = !(stop_at - sent_beats < 1150 && stop_at - sent_beats >= 900);
         settle();

         // new bounds: mostly small, some empty, some anywhere
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            span = ($urandom_range(0, 9) == 0) ? pick_in(301, SMALL_SPAN) : pick_in(1, 300);
            lo = pick_in(-32768, 32768 - span);
            hi = lo + span - 1;
         end else if (kind < 88) begin
            lo = pick_in(-32767, 32767);
            hi = lo - 1 - pick_in(0, lo + 32767);
         end else begin
            lo = pick_in(-32768, 32767);
            hi = pick_in(-32768, 32767);
         end
         if ($urandom_range(0, 1)) begin
            set_bound(svrm_pkg::REG_MIN_VALUE, lo);
            set_bound(svrm_pkg::REG_MAX_VALUE, hi);
         end else begin
            set_bound(svrm_pkg::REG_MAX_VALUE, hi);
            set_bound(svrm_pkg::REG_MIN_VALUE, lo);
         end
         span = hi - lo + 1;

         if (clears_left > 0 && $urandom_range(0, 19) == 0) begin
            clears_left--;
            issue_command(svrm_pkg::MODE_CLEAR, 0, 0);
         end

         // marks, mostly inside the range
         target_q.delete();
         repeat ($urandom_range(0, 40)) begin
            if (span > 0 && $urandom_range(0, 99) < 85) begin
               target = pick_in(lo, hi);
               target_q.push_back(target);
               issue_command(svrm_pkg::MODE_MARK, target, 0);
            end else begin
               k = $urandom_range(0, 2);
               target = (k == 0) ? lo - 1 : ((k == 1) ? hi + 1 : pick_in(-131072, 131071));
               issue_command(svrm_pkg::MODE_MARK, target, 0);
            end
         end

         if (span <= SMALL_SPAN && $urandom_range(0, 9) != 0)
            issue_command(svrm_pkg::MODE_BUILD, 0, 0);

         // bounds moved after the build leave the tables stale
         if ($urandom_range(0, 4) == 0) begin
            settle();
            set_bound(svrm_pkg::REG_MAX_VALUE, hi + pick_in(-8, 8));
            hi = hi_bound;
            span = hi - lo + 1;
         end

         repeat ($urandom_range(10, 40)) begin
            kind = $urandom_range(0, 99);
            if (kind < 35 && target_q.size() > 0) begin
               target = target_q[$urandom_range(0, target_q.size() - 1)];
               p = pick_pivot(target, lo, hi);
               issue_command(svrm_pkg::MODE_MAP, target - p, p);
            end else if (kind < 70) begin
               p = pick_pivot((span > 0) ? pick_in(lo, hi) : lo, lo, hi);
               k = (seen_total + 2 > 40) ? 40 : seen_total + 2;
               issue_command(svrm_pkg::MODE_UNMAP, pick_in(-k, k), p);
            end else if (kind < 80 && span > 0) begin
               issue_command(svrm_pkg::MODE_MARK, pick_in(lo, hi), 0);
            end else begin
               issue_command(noise_modes[$urandom_range(0, 5)], pick_in(-131072, 131071),
                             pick_in(-65536, 65535));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_mode          = svrm_pkg::MODE_CLEAR;
      req_operand_value = '0;
      req_prediction    = '0;
      csr_valid         = 1'b0;
      csr_index         = svrm_pkg::REG_MIN_VALUE;
      csr_data          = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_range();
      test_full_range();
      test_empty_range();
      test_clear_bitmap();
      test_random_phases();

      // drain, then allow the longest command to finish
      do @(posedge clock); while (rank_answers_due.size() != 0);
      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
